/* src/pda_pkg.sv */
// Shared types, constants and helper functions of the palm detection anchor decoder.
`default_nettype none

package pda_pkg;

    // Input geometry and anchor layout.
    localparam int INPUT_SIZE   = 128;
    localparam int MAP_A        = (INPUT_SIZE + 7) / 8;
    localparam int MAP_B        = (INPUT_SIZE + 15) / 16;
    localparam int COUNT_A      = MAP_A * MAP_A * 2;
    localparam int ANCHOR_COUNT = COUNT_A + MAP_B * MAP_B * 6;
    localparam int IDX_W        = $clog2(ANCHOR_COUNT + 1);
    localparam int COORD_W      = $clog2(MAP_A);
    localparam int SUB_W        = 3;
    localparam logic [SUB_W-1:0] SUB_MAX_A = SUB_W'(1);
    localparam logic [SUB_W-1:0] SUB_MAX_B = SUB_W'(5);

    // Anchor centers in Q0.13, stepped as quotient and remainder of
    // ((2 * pos + 1) * 8192 + map) / (2 * map).
    localparam int ANC_W = 13;
    localparam int DEN_A = 2 * MAP_A;
    localparam int DEN_B = 2 * MAP_B;
    localparam int R_W   = $clog2(DEN_A);
    localparam int Q0_A  = (8192 + MAP_A) / DEN_A;
    localparam int R0_A  = (8192 + MAP_A) % DEN_A;
    localparam int QS_A  = 16384 / DEN_A;
    localparam int RS_A  = 16384 % DEN_A;
    localparam int Q0_B  = (8192 + MAP_B) / DEN_B;
    localparam int R0_B  = (8192 + MAP_B) % DEN_B;
    localparam int QS_B  = 16384 / DEN_B;
    localparam int RS_B  = 16384 % DEN_B;

    // Regressors.
    localparam int NREG   = 18;
    localparam int REG_W  = 16;
    localparam int REGS_W = NREG * REG_W;
    localparam int NKP    = 14;
    localparam int KP_W   = NKP * REG_W;

    // Stream widths.
    localparam int S_TDATA_W = 16 + REGS_W;
    localparam int M_TDATA_W = 10 + 16 + 16 + 16 + 15 + 15 + KP_W;

    // Sigmoid datapath.
    localparam int A_W      = 12;
    localparam int EXP_N    = 12;
    localparam int E_W      = 31;
    localparam int P_W      = 30;
    localparam int PROD_W   = 61;
    localparam int D_W      = 32;
    localparam int REM_W    = 47;
    localparam int DK_W     = 48;
    localparam int Q_W      = 17;
    localparam int SIG_LAT  = 1 + EXP_N + 1 + Q_W;

    // Configuration registers.
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SCORE_THRESHOLD,
        REG_BEST_ONLY
    } cfg_reg_t;

    typedef struct packed {
        logic             in_range;
        logic [IDX_W-1:0] idx;
        logic [ANC_W-1:0] ax;
        logic [ANC_W-1:0] ay;
    } anchor_t;

    typedef struct packed {
        logic              last;
        logic              in_range;
        logic [IDX_W-1:0]  idx;
        logic [ANC_W-1:0]  ax;
        logic [ANC_W-1:0]  ay;
        logic [REGS_W-1:0] regs;
    } item_t;

    typedef struct packed {
        logic             cand;
        logic [IDX_W-1:0] idx;
        logic [15:0]      score;
        logic [ANC_W-1:0] ax;
        logic [ANC_W-1:0] ay;
    } cand_t;

    typedef struct packed {
        logic [KP_W-1:0] keypoints;
        logic [14:0]     box_height;
        logic [14:0]     box_width;
        logic [15:0]     box_top;
        logic [15:0]     box_left;
        logic [15:0]     score;
        logic [9:0]      detection_index;
    } result_t;

    // exp(-2^k / 256) in Q30 by repeated rounded squaring.
    function automatic logic [P_W-1:0] exp_pow(input int k);
        logic [63:0] p;
        int          i;
        p = 64'd1073741824 - 64'd4194304 + 64'd8192 - 64'd11;
        for (i = 0; i < k; i++) begin
            p = (p * p + 64'd536870912) >> 30;
        end
        return p[P_W-1:0];
    endfunction

    function automatic logic [15:0] sat16(input logic signed [17:0] v);
        logic [15:0] r;
        if (v > 18'sd32767) begin
            r = 16'h7FFF;
        end else if (v < -18'sd32768) begin
            r = 16'h8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* src/palm_detection_anchor_decode_core.sv */
// Top level of the palm detection anchor decoder.
//
// The s_ channel carries one detection per transfer: the score logit and 18
// regressors in s_tdata, with s_tlast on the final detection of a frame. The
// block numbers detections by anchor itself; detections past the last anchor
// produce nothing, but their s_tlast still ends the frame. The m_ channel
// carries decoded detections. In normal mode a detection whose score reaches
// the threshold is sent; in best-only mode a single best detection is sent
// with the frame's last transfer. Detections with a negative size are dropped.
// Each detection passes through the sigmoid pipeline (an input stage, 12
// product stages, one per exponent bit, a dividend stage and a 17-stage
// restoring divider), then one decision stage and one decode stage. One
// transfer is taken every cycle while s_tready is high. When m_tready is
// low, the pipeline keeps moving until a result reaches the decode stage
// while the output register is still full; then s_tready drops until the
// output transfer completes.
// Reset clears the anchor counter and the best-detection state and sets the
// threshold to 0x8000 and best-only mode off; no clearing pass is needed.
`default_nettype none

module palm_detection_anchor_decode_core (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [pda_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  wire logic [pda_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // score_logit, regress_0_3, regress_4_7, regress_8_11, regress_12_15,
    // regress_16_17
    input  wire logic [pda_pkg::S_TDATA_W-1:0]       s_tdata,
    input  wire logic                                s_tlast,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // detection_index, score, box_left, box_top, box_width, box_height,
    // keypoints_0_3, keypoints_4_7, keypoints_8_11, keypoints_12_13
    output logic [pda_pkg::M_TDATA_W-1:0]            m_tdata
);
    import pda_pkg::*;

    logic [15:0]       thr_reg;
    logic              best_only_reg;

    logic              en, s_acc;
    anchor_t           anc;
    item_t             in_item;
    item_t             dl_reg [SIG_LAT];
    logic [SIG_LAT-1:0] dv_reg;
    logic [15:0]       f_score;

    cand_t             g_cand;
    logic [REGS_W-1:0] g_regs;
    result_t           g_res;
    logic              g_keep, g_emit;

    logic              m_tvalid_reg;
    result_t           m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg       <= 16'h8000;
            best_only_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_addr))
                REG_SCORE_THRESHOLD: thr_reg       <= cfg_wdata[15:0];
                REG_BEST_ONLY:       best_only_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign g_emit   = g_cand.cand && g_keep;
    assign en       = !m_tvalid_reg || m_tready || !g_emit;
    assign s_tready = en;
    assign s_acc    = s_tvalid && en;

    pda_anchor_gen u_anchor (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (s_acc),
        .last    (s_tlast),
        .anc     (anc)
    );

    always_comb begin
        in_item.last     = s_tlast;
        in_item.in_range = anc.in_range;
        in_item.idx      = anc.idx;
        in_item.ax       = anc.ax;
        in_item.ay       = anc.ay;
        in_item.regs     = s_tdata[S_TDATA_W-1:16];
    end

    pda_sigmoid u_sigmoid (
        .aclk  (aclk),
        .en    (en),
        .logit (s_tdata[15:0]),
        .score (f_score)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_reg <= '0;
        end else if (en) begin
            dv_reg <= {dv_reg[SIG_LAT-2:0], s_acc};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dl_reg[0] <= in_item;
            for (int i = 1; i < SIG_LAT; i++) begin
                dl_reg[i] <= dl_reg[i-1];
            end
        end
    end

    pda_best_store u_best (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .f_valid   (dv_reg[SIG_LAT-1]),
        .f_item    (dl_reg[SIG_LAT-1]),
        .f_score   (f_score),
        .thr       (thr_reg),
        .best_only (best_only_reg),
        .g_cand    (g_cand),
        .g_regs    (g_regs)
    );

    pda_box_decode u_decode (
        .cand (g_cand),
        .regs (g_regs),
        .res  (g_res),
        .keep (g_keep)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en && g_emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && g_emit) begin
            m_data_reg <= g_res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_data_reg.keypoints, m_data_reg.box_height, m_data_reg.box_width,
                       m_data_reg.box_top, m_data_reg.box_left, m_data_reg.score,
                       m_data_reg.detection_index};

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled while the output side can take a transfer");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

endmodule

`default_nettype wire

/* src/pda_anchor_gen.sv */
// Anchor counter that tracks the index and the anchor center of the next item.
`default_nettype none

module pda_anchor_gen (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              step,
    input  wire logic              last,
    output pda_pkg::anchor_t       anc
);
    import pda_pkg::*;

    logic [IDX_W-1:0]   cnt_reg,   cnt_next;
    logic               layer_b_reg, layer_b_next;
    logic [SUB_W-1:0]   sub_reg,   sub_next;
    logic [COORD_W-1:0] col_reg,   col_next;
    logic [COORD_W-1:0] row_reg,   row_next;
    logic [ANC_W-1:0]   xq_reg,    xq_next;
    logic [ANC_W-1:0]   yq_reg,    yq_next;
    logic [R_W-1:0]     xr_reg,    xr_next;
    logic [R_W-1:0]     yr_reg,    yr_next;

    logic [COORD_W-1:0] coord_max;
    logic [SUB_W-1:0]   sub_max;
    logic [R_W:0]       den, rstep, xr_sum, yr_sum;
    logic [ANC_W-1:0]   qstep, q0;
    logic [R_W-1:0]     r0;
    logic               x_wrap, y_wrap;

    always_comb begin
        coord_max = layer_b_reg ? COORD_W'(MAP_B - 1) : COORD_W'(MAP_A - 1);
        sub_max   = layer_b_reg ? SUB_MAX_B : SUB_MAX_A;
        den       = layer_b_reg ? (R_W+1)'(DEN_B) : (R_W+1)'(DEN_A);
        rstep     = layer_b_reg ? (R_W+1)'(RS_B) : (R_W+1)'(RS_A);
        qstep     = layer_b_reg ? ANC_W'(QS_B) : ANC_W'(QS_A);
        q0        = layer_b_reg ? ANC_W'(Q0_B) : ANC_W'(Q0_A);
        r0        = layer_b_reg ? R_W'(R0_B) : R_W'(R0_A);
        xr_sum    = {1'b0, xr_reg} + rstep;
        yr_sum    = {1'b0, yr_reg} + rstep;
        x_wrap    = xr_sum >= den;
        y_wrap    = yr_sum >= den;
    end

    always_comb begin
        cnt_next     = cnt_reg;
        layer_b_next = layer_b_reg;
        sub_next     = sub_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        xq_next      = xq_reg;
        yq_next      = yq_reg;
        xr_next      = xr_reg;
        yr_next      = yr_reg;
        if (step) begin
            if (last) begin
                cnt_next     = '0;
                layer_b_next = 1'b0;
                sub_next     = '0;
                col_next     = '0;
                row_next     = '0;
                xq_next      = ANC_W'(Q0_A);
                yq_next      = ANC_W'(Q0_A);
                xr_next      = R_W'(R0_A);
                yr_next      = R_W'(R0_A);
            end else if (cnt_reg < IDX_W'(ANCHOR_COUNT)) begin
                cnt_next = cnt_reg + IDX_W'(1);
                if (sub_reg != sub_max) begin
                    sub_next = sub_reg + SUB_W'(1);
                end else begin
                    sub_next = '0;
                    if (col_reg != coord_max) begin
                        col_next = col_reg + COORD_W'(1);
                        xq_next  = xq_reg + qstep + ANC_W'(x_wrap);
                        xr_next  = x_wrap ? R_W'(xr_sum - den) : R_W'(xr_sum);
                    end else begin
                        col_next = '0;
                        xq_next  = q0;
                        xr_next  = r0;
                        if (row_reg != coord_max) begin
                            row_next = row_reg + COORD_W'(1);
                            yq_next  = yq_reg + qstep + ANC_W'(y_wrap);
                            yr_next  = y_wrap ? R_W'(yr_sum - den) : R_W'(yr_sum);
                        end else if (!layer_b_reg) begin
                            layer_b_next = 1'b1;
                            row_next     = '0;
                            xq_next      = ANC_W'(Q0_B);
                            yq_next      = ANC_W'(Q0_B);
                            xr_next      = R_W'(R0_B);
                            yr_next      = R_W'(R0_B);
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            layer_b_reg <= 1'b0;
            sub_reg     <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
            xq_reg      <= ANC_W'(Q0_A);
            yq_reg      <= ANC_W'(Q0_A);
            xr_reg      <= R_W'(R0_A);
            yr_reg      <= R_W'(R0_A);
        end else begin
            cnt_reg     <= cnt_next;
            layer_b_reg <= layer_b_next;
            sub_reg     <= sub_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            xq_reg      <= xq_next;
            yq_reg      <= yq_next;
            xr_reg      <= xr_next;
            yr_reg      <= yr_next;
        end
    end

    assign anc.in_range = cnt_reg < IDX_W'(ANCHOR_COUNT);
    assign anc.idx      = cnt_reg;
    assign anc.ax       = xq_reg;
    assign anc.ay       = yq_reg;

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= IDX_W'(ANCHOR_COUNT))
        else $error("anchor counter ran past the anchor count");

    a_layer_a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        !layer_b_reg |-> cnt_reg < IDX_W'(COUNT_A))
        else $error("first anchor layer holds an index beyond its size");

endmodule

`default_nettype wire

/* src/pda_sigmoid.sv */
// Pipelined sigmoid: exponent by conditional products, then a restoring divider.
`default_nettype none

module pda_sigmoid (
    input  wire logic        aclk,
    input  wire logic        en,
    input  wire logic [15:0] logit,
    output logic      [15:0] score
);
    import pda_pkg::*;

    localparam logic [PROD_W-1:0] HALF  = PROD_W'(1) << 29;
    localparam logic [E_W-1:0]    E_ONE = E_W'(1) << 30;

    logic [16:0]      mag;
    logic [A_W-1:0]   a_in;

    logic             neg_reg [EXP_N+1];
    logic [A_W-1:0]   a_reg   [EXP_N];
    logic [E_W-1:0]   e_reg   [EXP_N+1];
    logic [E_W-1:0]   e_nxt   [EXP_N];

    logic [D_W-1:0]   d_sum;
    logic [REM_W-1:0] num;

    logic [REM_W-1:0] rem_reg [Q_W];
    logic [D_W-1:0]   d_reg   [Q_W];
    logic [Q_W-1:0]   q_reg   [Q_W];
    logic [REM_W-1:0] rem_nxt [Q_W];
    logic [Q_W-1:0]   q_nxt   [Q_W];

    always_comb begin
        mag  = logit[15] ? (17'd0 - {logit[15], logit}) : {1'b0, logit};
        a_in = (mag > 17'd4095) ? {A_W{1'b1}} : mag[A_W-1:0];
    end

    for (genvar k = 0; k < EXP_N; k++) begin : g_exp
        localparam logic [P_W-1:0] PK = exp_pow(k);
        logic [PROD_W-1:0] prod;
        assign prod     = PROD_W'(e_reg[k]) * PROD_W'(PK) + HALF;
        assign e_nxt[k] = a_reg[k][k] ? prod[PROD_W-1:30] : e_reg[k];
    end

    always_comb begin
        d_sum = D_W'(E_ONE) + D_W'(e_reg[EXP_N]);
        if (neg_reg[EXP_N]) begin
            num = {e_reg[EXP_N], 16'd0} + REM_W'(d_sum >> 1);
        end else begin
            num = (REM_W'(1) << 46) + REM_W'(d_sum >> 1);
        end
    end

    for (genvar j = 0; j < Q_W; j++) begin : g_div
        localparam int SH = Q_W - 1 - j;
        logic [DK_W-1:0] dk;
        logic            ge;
        logic [Q_W-1:0]  q_in;
        assign dk         = DK_W'(d_reg[j]) << SH;
        assign ge         = {1'b0, rem_reg[j]} >= dk;
        assign rem_nxt[j] = ge ? (rem_reg[j] - dk[REM_W-1:0]) : rem_reg[j];
        if (j == 0) begin : g_first
            assign q_in = '0;
        end else begin : g_rest
            assign q_in = q_reg[j-1];
        end
        assign q_nxt[j] = {q_in[Q_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            neg_reg[0] <= logit[15];
            a_reg[0]   <= a_in;
            e_reg[0]   <= E_ONE;
            for (int k = 0; k < EXP_N; k++) begin
                neg_reg[k+1] <= neg_reg[k];
                e_reg[k+1]   <= e_nxt[k];
            end
            for (int k = 0; k < EXP_N - 1; k++) begin
                a_reg[k+1] <= a_reg[k];
            end
            rem_reg[0] <= num;
            d_reg[0]   <= d_sum;
            for (int j = 0; j < Q_W; j++) begin
                q_reg[j] <= q_nxt[j];
            end
            for (int j = 0; j < Q_W - 1; j++) begin
                rem_reg[j+1] <= rem_nxt[j];
                d_reg[j+1]   <= d_reg[j];
            end
        end
    end

    assign score = q_reg[Q_W-1][Q_W-1] ? 16'hFFFF : q_reg[Q_W-1][15:0];

endmodule

`default_nettype wire

/* src/pda_best_store.sv */
// Score decision stage with the best-detection store and its regressor memory.
`default_nettype none

module pda_best_store (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      en,
    input  wire logic                      f_valid,
    input  wire pda_pkg::item_t            f_item,
    input  wire logic [15:0]               f_score,
    input  wire logic [15:0]               thr,
    input  wire logic                      best_only,
    output pda_pkg::cand_t                 g_cand,
    output logic [pda_pkg::REGS_W-1:0]     g_regs
);
    import pda_pkg::*;

    logic [REGS_W-1:0] best_mem [2];
    logic [REGS_W-1:0] rd_data_reg;
    logic              frame_reg;

    logic              best_present_reg;
    logic [15:0]       best_score_reg;
    logic [IDX_W-1:0]  best_idx_reg;
    logic [ANC_W-1:0]  best_ax_reg;
    logic [ANC_W-1:0]  best_ay_reg;

    cand_t             g_cand_reg, g_cand_next;
    logic              g_valid_reg;
    logic              g_use_mem_reg;
    logic [REGS_W-1:0] g_item_regs_reg;

    logic [15:0]       bar;
    logic              pass, new_best, emit_item, emit_best;

    always_comb begin
        bar       = best_present_reg ? best_score_reg : thr;
        pass      = f_valid && f_item.in_range && (f_score >= thr);
        new_best  = pass && (f_score > bar);
        emit_item = pass && !best_only;
        emit_best = f_valid && f_item.last && best_only && (best_present_reg || new_best);

        g_cand_next.cand = emit_item || emit_best;
        if (emit_best && !new_best) begin
            g_cand_next.idx   = best_idx_reg;
            g_cand_next.score = best_score_reg;
            g_cand_next.ax    = best_ax_reg;
            g_cand_next.ay    = best_ay_reg;
        end else begin
            g_cand_next.idx   = f_item.idx;
            g_cand_next.score = f_score;
            g_cand_next.ax    = f_item.ax;
            g_cand_next.ay    = f_item.ay;
        end
    end

    // The read forwards a write to the same entry in the same cycle.
    always_ff @(posedge aclk) begin
        if (en) begin
            if (new_best) begin
                best_mem[frame_reg] <= f_item.regs;
                rd_data_reg         <= f_item.regs;
            end else begin
                rd_data_reg         <= best_mem[frame_reg];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_reg        <= 1'b0;
            best_present_reg <= 1'b0;
            best_score_reg   <= '0;
            best_idx_reg     <= '0;
            g_valid_reg      <= 1'b0;
        end else if (en) begin
            g_valid_reg <= g_cand_next.cand;
            if (f_valid && f_item.last) begin
                frame_reg        <= !frame_reg;
                best_present_reg <= 1'b0;
                best_score_reg   <= '0;
                best_idx_reg     <= '0;
            end else if (new_best) begin
                best_present_reg <= 1'b1;
                best_score_reg   <= f_score;
                best_idx_reg     <= f_item.idx;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (new_best) begin
                best_ax_reg <= f_item.ax;
                best_ay_reg <= f_item.ay;
            end
            g_cand_reg      <= g_cand_next;
            g_use_mem_reg   <= emit_best;
            g_item_regs_reg <= f_item.regs;
        end
    end

    always_comb begin
        g_cand      = g_cand_reg;
        g_cand.cand = g_valid_reg;
    end

    assign g_regs = g_use_mem_reg ? rd_data_reg : g_item_regs_reg;

    a_best_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        !best_present_reg |-> best_score_reg == 16'd0)
        else $error("best score kept while no best detection is held");

endmodule

`default_nettype wire

/* src/pda_box_decode.sv */
// Box and keypoint decode of one detection relative to its anchor center.
`default_nettype none

module pda_box_decode (
    input  wire pda_pkg::cand_t                 cand,
    input  wire logic [pda_pkg::REGS_W-1:0]     regs,
    output pda_pkg::result_t                    res,
    output logic                                keep
);
    import pda_pkg::*;

    logic [15:0]        r0, r1, w, h, lane;
    logic signed [17:0] ax_x, ay_x, sum;

    always_comb begin
        r0   = regs[0*REG_W +: REG_W];
        r1   = regs[1*REG_W +: REG_W];
        w    = regs[2*REG_W +: REG_W];
        h    = regs[3*REG_W +: REG_W];
        ax_x = {5'b00000, cand.ax};
        ay_x = {5'b00000, cand.ay};
        keep = !w[15] && !h[15];

        res.detection_index = 10'(cand.idx);
        res.score           = cand.score;
        res.box_left  = sat16({{2{r0[15]}}, r0} + ax_x - {{3{w[15]}}, w[15:1]});
        res.box_top   = sat16({{2{r1[15]}}, r1} + ay_x - {{3{h[15]}}, h[15:1]});
        res.box_width  = w[14:0];
        res.box_height = h[14:0];

        res.keypoints = '0;
        for (int i = 0; i < NKP; i++) begin
            lane = regs[(4 + i)*REG_W +: REG_W];
            sum  = {{2{lane[15]}}, lane} + (((i % 2) == 0) ? ax_x : ay_x);
            res.keypoints[i*REG_W +: REG_W] = sat16(sum);
        end
    end

endmodule

`default_nettype wire
